### hdl/wcpf_pkg.sv
// Shared types and constants for the window classifier with persistence filter.
// Depends on nothing; imported by wcpf_classify and the top level.
package wcpf_pkg;

    localparam int NUM_CH        = 8;
    localparam int SAMPLE_W      = 10;
    localparam int CODE_W        = 2;
    localparam int PAT_W         = NUM_CH * CODE_W;
    localparam int NUM_REGS      = 8;
    localparam int REG_IDX_W     = $clog2(NUM_REGS);
    localparam int RUNS_W        = 2;
    localparam logic [RUNS_W-1:0] RUNS_MAX      = '1;
    localparam logic [RUNS_W-1:0] CONFIRM_COUNT = 2'd2;

    localparam logic [CODE_W-1:0] CODE_NONE   = 2'b00;
    localparam logic [CODE_W-1:0] CODE_WALL   = 2'b01;
    localparam logic [CODE_W-1:0] CODE_OBJECT = 2'b11;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_OBJ_DBL_LO  = 3'd0,
        REG_OBJ_DBL_HI  = 3'd1,
        REG_OBJ_SGL_LO  = 3'd2,
        REG_OBJ_SGL_HI  = 3'd3,
        REG_WALL_DBL_LO = 3'd4,
        REG_WALL_DBL_HI = 3'd5,
        REG_WALL_SGL_LO = 3'd6,
        REG_WALL_SGL_HI = 3'd7
    } t_reg_idx;

    typedef logic [SAMPLE_W-1:0]              t_sample;
    typedef logic [NUM_CH-1:0][SAMPLE_W-1:0]  t_sample_vec;
    typedef logic [NUM_REGS-1:0][SAMPLE_W-1:0] t_cfg_vec;
    typedef logic [PAT_W-1:0]                 t_pattern;

endpackage

### hdl/wcpf_classify.sv
// Eight parallel window classifiers that build the 16-bit channel pattern.
// Depends on wcpf_pkg for the register layout, codes and vector types.
module wcpf_classify
    import wcpf_pkg::*;
(
    input  t_sample_vec i_sample,
    input  t_cfg_vec    i_cfg,
    output t_pattern    o_pattern
);

    function automatic logic in_win(t_sample v, t_sample lo, t_sample hi);
        return (v > lo) && (v < hi);
    endfunction

    always_comb begin
        o_pattern = '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            // Object windows win over wall windows when both match.
            if (in_win(i_sample[ch], i_cfg[REG_OBJ_DBL_LO], i_cfg[REG_OBJ_DBL_HI]) ||
                in_win(i_sample[ch], i_cfg[REG_OBJ_SGL_LO], i_cfg[REG_OBJ_SGL_HI])) begin
                o_pattern[ch*CODE_W +: CODE_W] = CODE_OBJECT;
            end else if (in_win(i_sample[ch], i_cfg[REG_WALL_DBL_LO], i_cfg[REG_WALL_DBL_HI]) ||
                         in_win(i_sample[ch], i_cfg[REG_WALL_SGL_LO],
                                i_cfg[REG_WALL_SGL_HI])) begin
                o_pattern[ch*CODE_W +: CODE_W] = CODE_WALL;
            end else begin
                o_pattern[ch*CODE_W +: CODE_W] = CODE_NONE;
            end
        end
    end

endmodule

### hdl/window_classify_persistence_filter.sv
// Window classifier with persistence filter, top level.
// An accepted word is held in the input register; its result goes to the result register.
// Throughput: one word per cycle while the output is not stalled. The two registers
// form a two-stage pipeline, so a new word is taken while a result waits.
// Reset (synchronous, active low) clears the thresholds, the run history and
// both pipeline stages. Depends on wcpf_pkg and wcpf_classify.
module window_classify_persistence_filter
    import wcpf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [REG_IDX_W-1:0] i_cfg_index,
    input  logic [SAMPLE_W-1:0]  i_cfg_data,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [SAMPLE_W-1:0]  i_sample_0,
    input  logic [SAMPLE_W-1:0]  i_sample_1,
    input  logic [SAMPLE_W-1:0]  i_sample_2,
    input  logic [SAMPLE_W-1:0]  i_sample_3,
    input  logic [SAMPLE_W-1:0]  i_sample_4,
    input  logic [SAMPLE_W-1:0]  i_sample_5,
    input  logic [SAMPLE_W-1:0]  i_sample_6,
    input  logic [SAMPLE_W-1:0]  i_sample_7,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [PAT_W-1:0]     o_confirmed_pattern,
    output logic                 o_detected
);

    t_cfg_vec          r_cfg;
    logic              r_s1_valid;
    t_sample_vec       r_s1_sample;
    t_pattern          r_prev;
    logic [RUNS_W-1:0] r_runs;
    logic              r_out_valid;
    t_pattern          r_out_pattern;
    logic              r_out_detected;

    t_pattern          pattern;
    logic [RUNS_W-1:0] n_runs;
    t_pattern          n_confirmed;
    logic              out_load;
    logic              in_accept;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // The result register can take a word when it is empty or being drained.
    assign out_load   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !out_load;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (out_load) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_sample <= {i_sample_7, i_sample_6, i_sample_5, i_sample_4,
                            i_sample_3, i_sample_2, i_sample_1, i_sample_0};
        end
    end

    wcpf_classify u_classify (
        .i_sample  (r_s1_sample),
        .i_cfg     (r_cfg),
        .o_pattern (pattern)
    );

    always_comb begin
        if (pattern == r_prev) begin
            n_runs = (r_runs == RUNS_MAX) ? r_runs : r_runs + 1'b1;
        end else begin
            n_runs = '0;
        end
        n_confirmed = (n_runs >= CONFIRM_COUNT) ? pattern : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_runs      <= '0;
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_prev <= pattern;
                r_runs <= n_runs;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_s1_valid) begin
            r_out_pattern  <= n_confirmed;
            r_out_detected <= (n_confirmed != '0);
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_confirmed_pattern = r_out_pattern;
    assign o_detected          = r_out_detected;

    // A detection can only be shown once the run count has reached the threshold.
    a_detect_needs_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_detected |-> r_runs >= CONFIRM_COUNT)
        else $error("detection shown without enough repeats");

    // A shown nonzero pattern is the last classified pattern.
    a_detect_matches_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_detected |-> o_confirmed_pattern == r_prev)
        else $error("confirmed pattern differs from history");

    // A changed pattern restarts the run count.
    a_change_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && r_s1_valid && (pattern != r_prev) |=> r_runs == '0)
        else $error("run count not restarted on change");

    // The input side is held off only while both stages are occupied.
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid && r_out_valid)
        else $error("input stalled with room in the pipeline");

endmodule

### bench/window_classify_persistence_filter_test.sv
// Testbench for the window classifier with persistence filter.
// Depends on wcpf_pkg and window_classify_persistence_filter. A scoreboard class predicts
// every result word from the thresholds and run history and checks the words in order.
module window_classify_persistence_filter_test;
    import wcpf_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 128;
    localparam int NUM_PHASES      = 8;

    typedef struct {
        t_pattern pat;
        logic     det;
    } t_confirm;

    class pattern_scoreboard;
        t_sample     thr[NUM_REGS];
        t_pattern    prev_pat;
        logic [RUNS_W-1:0] runs;
        t_confirm    expected_q[$];
        int          mismatches;
        int          checked;
        int          confirmed_seen;

        function new();
            foreach (thr[i]) thr[i] = '0;
            prev_pat       = '0;
            runs           = '0;
            mismatches     = 0;
            checked        = 0;
            confirmed_seen = 0;
        endfunction

        function void set_threshold(t_reg_idx idx, t_sample val);
            thr[idx] = val;
        endfunction

        function bit in_band(t_sample v, t_reg_idx lo, t_reg_idx hi);
            return (v > thr[lo]) && (v < thr[hi]);
        endfunction

        function logic [CODE_W-1:0] classify(t_sample v);
            if (in_band(v, REG_OBJ_DBL_LO, REG_OBJ_DBL_HI) ||
                in_band(v, REG_OBJ_SGL_LO, REG_OBJ_SGL_HI))
                return CODE_OBJECT;
            if (in_band(v, REG_WALL_DBL_LO, REG_WALL_DBL_HI) ||
                in_band(v, REG_WALL_SGL_LO, REG_WALL_SGL_HI))
                return CODE_WALL;
            return CODE_NONE;
        endfunction

        function void note_measurement(t_sample_vec s);
            t_pattern pat;
            t_confirm c;
            for (int ch = 0; ch < NUM_CH; ch++)
                pat[ch*CODE_W +: CODE_W] = classify(s[ch]);
            // The run counter saturates, so a pattern held long enough stays confirmed.
            if (pat == prev_pat) begin
                if (runs != RUNS_MAX)
                    runs = runs + 1'b1;
            end else begin
                runs = '0;
            end
            prev_pat = pat;
            c.pat = (runs >= CONFIRM_COUNT) ? pat : '0;
            c.det = (c.pat != '0);
            expected_q.push_back(c);
        endfunction

        function void check_result(t_pattern pat, logic det);
            t_confirm c;
            checked++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result word pattern=%h detected=%b", pat, det);
                return;
            end
            c = expected_q.pop_front();
            if (pat !== c.pat || det !== c.det) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d: expected pattern=%h detected=%b, got %h %b",
                             checked, c.pat, c.det, pat, det);
            end
            if (det === 1'b1)
                confirmed_seen++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [REG_IDX_W-1:0] i_cfg_index = '0;
    logic [SAMPLE_W-1:0]  i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [SAMPLE_W-1:0]  i_sample_0 = '0;
    logic [SAMPLE_W-1:0]  i_sample_1 = '0;
    logic [SAMPLE_W-1:0]  i_sample_2 = '0;
    logic [SAMPLE_W-1:0]  i_sample_3 = '0;
    logic [SAMPLE_W-1:0]  i_sample_4 = '0;
    logic [SAMPLE_W-1:0]  i_sample_5 = '0;
    logic [SAMPLE_W-1:0]  i_sample_6 = '0;
    logic [SAMPLE_W-1:0]  i_sample_7 = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [PAT_W-1:0]     o_confirmed_pattern;
    logic                 o_detected;

    pattern_scoreboard sb;
    int unsigned cycle_count = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          sent_total = 0;
    int          settings_total = 0;

    window_classify_persistence_filter uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_sample_0          (i_sample_0),
        .i_sample_1          (i_sample_1),
        .i_sample_2          (i_sample_2),
        .i_sample_3          (i_sample_3),
        .i_sample_4          (i_sample_4),
        .i_sample_5          (i_sample_5),
        .i_sample_6          (i_sample_6),
        .i_sample_7          (i_sample_7),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_confirmed_pattern (o_confirmed_pattern),
        .o_detected          (o_detected)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("window_classify_persistence_filter: mismatch");
            $finish;
        end
    end

    always @(negedge i_clk)
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge i_clk)
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0)
            sb.check_result(o_confirmed_pattern, o_detected);

    task automatic write_reg(input t_reg_idx idx, input t_sample val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.set_threshold(idx, val);
    endtask

    task automatic program_windows(input t_cfg_vec w);
        for (int i = 0; i < NUM_REGS; i++)
            write_reg(t_reg_idx'(i), w[i]);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        settings_total++;
    endtask

    task automatic send_measurement(input t_sample_vec s);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample_0 <= s[0];
        i_sample_1 <= s[1];
        i_sample_2 <= s[2];
        i_sample_3 <= s[3];
        i_sample_4 <= s[4];
        i_sample_5 <= s[5];
        i_sample_6 <= s[6];
        i_sample_7 <= s[7];
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_measurement(s);
        sent_total++;
    endtask

    // Drops valid after the last accepted word and holds until every result is back.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    function automatic t_cfg_vec window_setting(int sel);
        t_cfg_vec w;
        int lo;
        int hi;
        w = '0;
        case (sel)
            0: begin
                // Wall window overlaps the first object window; two narrow windows.
                w[REG_OBJ_DBL_LO]  = 10'd100;
                w[REG_OBJ_DBL_HI]  = 10'd200;
                w[REG_OBJ_SGL_LO]  = 10'd500;
                w[REG_OBJ_SGL_HI]  = 10'd502;
                w[REG_WALL_DBL_LO] = 10'd150;
                w[REG_WALL_DBL_HI] = 10'd600;
                w[REG_WALL_SGL_LO] = 10'd900;
                w[REG_WALL_SGL_HI] = 10'd901;
            end
            1: w = '1;
            2: begin
                w[REG_OBJ_DBL_HI]  = 10'd1023;
                w[REG_OBJ_SGL_HI]  = 10'd1023;
                w[REG_WALL_DBL_HI] = 10'd1023;
                w[REG_WALL_SGL_HI] = 10'd1023;
            end
            3: begin
                // Inverted object windows are empty, so only walls can show.
                w[REG_OBJ_DBL_LO]  = 10'd800;
                w[REG_OBJ_DBL_HI]  = 10'd300;
                w[REG_OBJ_SGL_LO]  = 10'd1023;
                w[REG_OBJ_SGL_HI]  = 10'd0;
                w[REG_WALL_DBL_LO] = 10'd0;
                w[REG_WALL_DBL_HI] = 10'd512;
                w[REG_WALL_SGL_LO] = 10'd511;
                w[REG_WALL_SGL_HI] = 10'd1023;
            end
            default: begin
                for (int k = 0; k < NUM_REGS; k += 2) begin
                    lo = $urandom_range(0, 1023);
                    w[k] = t_sample'(lo);
                    if ($urandom_range(0, 9) < 8) begin
                        hi = lo + int'($urandom_range(0, 400));
                        w[k+1] = t_sample'((hi > 1023) ? 1023 : hi);
                    end else
                        w[k+1] = t_sample'($urandom_range(0, 1023));
                end
            end
        endcase
        return w;
    endfunction

    // Readings cluster around the thresholds so both sides of every bound are hit.
    function automatic t_sample pick_sample();
        int v;
        if ($urandom_range(0, 9) < 3)
            return t_sample'($urandom_range(0, 1023));
        v = int'(sb.thr[$urandom_range(0, NUM_REGS - 1)]) + int'($urandom_range(0, 2)) - 1;
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return t_sample'(v);
    endfunction

    task automatic run_phase(input int mode);
        t_sample_vec base;
        int          sent;
        int          len;
        bit          paused;
        sent   = 0;
        paused = 0;
        case (mode)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 85; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 85; end
            default: begin send_idle_pct = 25; stall_pct = 25; end
        endcase
        while (sent < ITEMS_PER_PHASE) begin
            if (!paused && sent >= ITEMS_PER_PHASE / 2) begin
                drain();
                paused = 1;
            end
            for (int ch = 0; ch < NUM_CH; ch++)
                base[ch] = pick_sample();
            if ($urandom_range(0, 9) < 7) begin
                // Mostly repeated measurements, so patterns get confirmed and saturate.
                len = $urandom_range(1, 6);
                for (int r = 0; r < len; r++) begin
                    if (r != 0)
                        for (int ch = 0; ch < NUM_CH; ch++)
                            if ($urandom_range(0, 15) == 0)
                                base[ch] = pick_sample();
                    send_measurement(base);
                    sent++;
                end
            end else begin
                for (int ch = 0; ch < NUM_CH; ch++)
                    base[ch] = t_sample'($urandom_range(0, 1023));
                send_measurement(base);
                sent++;
            end
        end
        drain();
    endtask

    initial begin
        t_sample_vec v;
        sb = new();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The first measurements after reset see all windows empty.
        send_measurement('0);
        send_measurement('1);
        send_measurement('0);
        drain();

        program_windows(window_setting(0));
        // Readings on and next to each bound, an overlap, an empty window, both extremes.
        v[0] = 10'd100;
        v[1] = 10'd101;
        v[2] = 10'd199;
        v[3] = 10'd200;
        v[4] = 10'd501;
        v[5] = 10'd900;
        v[6] = 10'd1023;
        v[7] = 10'd0;
        repeat (6) send_measurement(v);
        v[0] = 10'd160;
        v[5] = 10'd599;
        v[7] = 10'd502;
        repeat (3) send_measurement(v);
        v[3] = 10'd600;
        send_measurement(v);
        v[3] = 10'd200;
        repeat (4) send_measurement(v);
        v = '1;
        repeat (3) send_measurement(v);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct = 0;
            stall_pct     = 0;
            program_windows(window_setting(p));
            run_phase(p % 4);
        end

        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (8) @(posedge i_clk);

        $display("Covered %0d measurements under %0d threshold settings, four pacing modes.",
                 sent_total, settings_total);
        $display("Checked %0d result words, %0d of them with a confirmed nonzero pattern.",
                 sb.checked, sb.confirmed_seen);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("window_classify_persistence_filter: match");
        end else begin
            $display("window_classify_persistence_filter: mismatch");
        end
        $finish;
    end

endmodule

### window_classify_persistence_filter.f
hdl/wcpf_pkg.sv
hdl/wcpf_classify.sv
hdl/window_classify_persistence_filter.sv
bench/window_classify_persistence_filter_test.sv
